>>> sv/rqs_pkg.sv
// Shared types, constants and control/status bundles of the randomized quickselect unit.
`timescale 1ns / 1ps

package rqs_pkg;

  localparam int VALUE_BITS    = 16;
  localparam int RANK_BITS     = 11;
  localparam int POS_BITS      = 10;
  localparam int COUNT_BITS    = 20;
  localparam int SEED_BITS     = 16;
  localparam int MAX_ITEMS_DEF = 1024;

  localparam logic [SEED_BITS-1:0]  LFSR_TAPS = 16'hB400;
  localparam logic [SEED_BITS-1:0]  SEED_ONE  = 16'h0001;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] item_value;
    logic [RANK_BITS-1:0]         wanted_rank;
    logic                         is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] kth_value;
    logic [POS_BITS-1:0]          kth_position;
    logic [COUNT_BITS-1:0]        compare_count;
    logic [COUNT_BITS-1:0]        swap_count;
    logic                         rank_error;
  } out_item_t;

  // store read address source
  typedef enum logic [2:0] {
    RD_LO,
    RD_PIV,
    RD_J,
    RD_MID,
    RD_POS
  } rd_sel_t;

  // store write address/data source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_LO_RDATA,
    WR_PIV_TMP,
    WR_J_RDATA,
    WR_MID_TMP,
    WR_MID_PV
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    start_sel;
    logic    err_out;
    logic    res_out;
    logic    lfsr_step;
    logic    mod_start;
    logic    piv_ld;
    logic    tmp_ld;
    logic    pv_ld;
    logic    scan_init;
    logic    j_inc;
    logic    mid_inc;
    logic    cmp_inc;
    logic    swp_inc;
    logic    narrow;
    logic    pos_lo;
    logic    pos_mid;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic rank_bad;
    logic lo_ge_hi;
    logic j_at_hi;
    logic less;
    logic rank_eq;
    logic mod_done;
    logic out_free;
  } sts_t;

endpackage

>>> sv/rqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/rqs_mod.sv
// Bit-serial restoring remainder unit: LFSR word modulo window size, one bit per cycle.
`timescale 1ns / 1ps

module rqs_mod #(
  parameter int DW = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rqs_pkg::SEED_BITS-1:0]  dividend,
  input  logic [DW-1:0]                  divisor,
  output logic                           done,
  output logic [DW-1:0]                  rem
);
  import rqs_pkg::*;

  localparam int SW = $clog2(SEED_BITS);

  logic                 busy_r;
  logic                 done_r;
  logic [SW-1:0]        step_r;
  logic [SEED_BITS-1:0] sh_r;
  logic [DW-1:0]        rem_r;
  logic [DW:0]          trial;
  logic [DW:0]          diff;
  logic                 ge;

  assign trial = {rem_r, sh_r[SEED_BITS-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= SW'(SEED_BITS - 1);
      sh_r   <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_r  <= {sh_r[SEED_BITS-2:0], 1'b0};
      if (step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        step_r <= step_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < divisor))
    else $error("remainder not below divisor");
`endif

endmodule

>>> sv/rqs_datapath.sv
// Datapath: element store, window registers, pivot LFSR, counters and result register.
`timescale 1ns / 1ps

module rqs_datapath #(
  parameter int MAX_ITEMS = rqs_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rqs_pkg::SEED_BITS-1:0] cfg_wr_data,
  input  rqs_pkg::in_item_t             in_item,
  input  rqs_pkg::cmd_t                 cmd,
  output rqs_pkg::sts_t                 sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rqs_pkg::out_item_t            out_item
);
  import rqs_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int RW = (CW > RANK_BITS) ? CW : RANK_BITS;

  logic [CW-1:0]                cnt_r;
  logic [IW-1:0]                lo_r, hi_r, mid_r, j_r, piv_r, pos_r;
  logic [CW-1:0]                rank_r;
  logic [SEED_BITS-1:0]         lfsr_r, lfsr_nxt;
  logic [COUNT_BITS-1:0]        cmp_r, swp_r;
  logic [VALUE_BITS-1:0]        tmp_r;
  logic signed [VALUE_BITS-1:0] pv_r;
  logic                         out_valid_r;
  out_item_t                    out_r;

  logic                  store_ok;
  logic [CW-1:0]         n_new;
  logic [RW-1:0]         rank_ext;
  logic [CW-1:0]         size;
  logic [CW-1:0]         left_size;
  logic [CW-1:0]         mod_rem;
  logic                  mod_done;
  logic                  ram_we;
  logic [IW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;
  logic [31:0]           pos_ext;

  assign store_ok  = cnt_r < CW'(MAX_ITEMS);
  assign n_new     = store_ok ? cnt_r + CW'(1) : cnt_r;
  assign rank_ext  = RW'(in_item.wanted_rank);
  assign size      = CW'(hi_r) - CW'(lo_r) + CW'(1);
  assign left_size = CW'(mid_r) - CW'(lo_r) + CW'(1);
  assign lfsr_nxt  = {1'b0, lfsr_r[SEED_BITS-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);
  assign pos_ext   = 32'(pos_r);

  // store address and data steering
  always_comb begin
    ram_we = 1'b0;
    waddr  = lo_r;
    wdata  = rdata;
    case (cmd.wr_sel)
      WR_NONE: begin
        ram_we = 1'b0;
      end
      WR_LOAD: begin
        ram_we = store_ok;
        waddr  = cnt_r[IW-1:0];
        wdata  = in_item.item_value;
      end
      WR_LO_RDATA: begin
        ram_we = 1'b1;
      end
      WR_PIV_TMP: begin
        ram_we = 1'b1;
        waddr  = piv_r;
        wdata  = tmp_r;
      end
      WR_J_RDATA: begin
        ram_we = 1'b1;
        waddr  = j_r;
      end
      WR_MID_TMP: begin
        ram_we = 1'b1;
        waddr  = mid_r;
        wdata  = tmp_r;
      end
      WR_MID_PV: begin
        ram_we = 1'b1;
        waddr  = mid_r;
        wdata  = pv_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_LO:   raddr = lo_r;
      RD_PIV:  raddr = piv_r;
      RD_J:    raddr = j_r;
      RD_MID:  raddr = mid_r;
      RD_POS:  raddr = pos_r;
      default: raddr = lo_r;
    endcase
  end

  rqs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rqs_mod #(
    .DW (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (lfsr_r),
    .divisor  (size),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      rank_r      <= '0;
      lfsr_r      <= SEED_ONE;
      cmp_r       <= '0;
      swp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lfsr_r <= (cfg_wr_data == '0) ? SEED_ONE : cfg_wr_data;
      end else if (cmd.lfsr_step) begin
        lfsr_r <= lfsr_nxt;
      end

      if (cmd.load) begin
        cnt_r <= in_item.is_last ? '0 : n_new;
      end

      if (cmd.start_sel) begin
        lo_r   <= '0;
        hi_r   <= IW'(n_new - CW'(1));
        rank_r <= rank_ext[CW-1:0];
        cmp_r  <= '0;
        swp_r  <= '0;
      end else begin
        if (cmd.cmp_inc && cmp_r != COUNT_MAX) begin
          cmp_r <= cmp_r + 1'b1;
        end
        if (cmd.swp_inc && swp_r != COUNT_MAX) begin
          swp_r <= swp_r + 1'b1;
        end
        if (cmd.narrow) begin
          if (rank_r < left_size) begin
            hi_r <= mid_r - 1'b1;
          end else begin
            lo_r   <= mid_r + 1'b1;
            rank_r <= rank_r - left_size;
          end
        end
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.res_out || cmd.err_out) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.piv_ld) begin
      piv_r <= lo_r + mod_rem[IW-1:0];
    end
    if (cmd.tmp_ld) begin
      tmp_r <= rdata;
    end
    if (cmd.pv_ld) begin
      pv_r <= rdata;
    end
    if (cmd.scan_init) begin
      j_r   <= lo_r + 1'b1;
      mid_r <= lo_r;
    end else begin
      if (cmd.j_inc) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.mid_inc) begin
        mid_r <= mid_r + 1'b1;
      end
    end
    if (cmd.pos_lo) begin
      pos_r <= lo_r;
    end else if (cmd.pos_mid) begin
      pos_r <= mid_r;
    end
    if (cmd.res_out) begin
      out_r.kth_value     <= rdata;
      out_r.kth_position  <= pos_ext[POS_BITS-1:0];
      out_r.compare_count <= cmp_r;
      out_r.swap_count    <= swp_r;
      out_r.rank_error    <= 1'b0;
    end else if (cmd.err_out) begin
      out_r.kth_value     <= '0;
      out_r.kth_position  <= '0;
      out_r.compare_count <= '0;
      out_r.swap_count    <= '0;
      out_r.rank_error    <= 1'b1;
    end
  end

  always_comb begin
    sts.last     = in_item.is_last;
    sts.rank_bad = (rank_ext == '0) || (rank_ext > RW'(n_new));
    sts.lo_ge_hi = lo_r >= hi_r;
    sts.j_at_hi  = j_r == hi_r;
    sts.less     = $signed(rdata) < pv_r;
    sts.rank_eq  = rank_r == left_size;
    sts.mod_done = mod_done;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("window low above window high");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("pivot LFSR stuck at zero");

  a_swaps_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.start_sel |=> swp_r >= $past(swp_r))
    else $error("swap count decreased within a selection");
`endif

endmodule

>>> sv/rqs_ctrl.sv
// Controller: load, pivot choice, Lomuto partition sequencing and result hand-off.
`timescale 1ns / 1ps

module rqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rqs_pkg::sts_t sts,
  output rqs_pkg::cmd_t cmd
);
  import rqs_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD,
    S_ERR,
    S_CHECK,
    S_MOD_GO,
    S_MOD_WAIT,
    S_PV_A,
    S_PV_B,
    S_PV_C,
    S_PV_D,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SW_RD,
    S_SW_A,
    S_SW_B,
    S_FIN_RD,
    S_FIN_A,
    S_FIN_B,
    S_NARROW,
    S_RES_RD,
    S_RES_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = RD_LO;
    cmd.wr_sel = WR_NONE;
    in_ready   = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cmd.wr_sel = WR_LOAD;
          if (sts.last) begin
            if (sts.rank_bad) begin
              state_nxt = S_ERR;
            end else begin
              cmd.start_sel = 1'b1;
              state_nxt     = S_CHECK;
            end
          end
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.err_out = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_CHECK: begin
        if (sts.lo_ge_hi) begin
          cmd.pos_lo = 1'b1;
          state_nxt  = S_RES_RD;
        end else begin
          cmd.lfsr_step = 1'b1;
          state_nxt     = S_MOD_GO;
        end
      end
      S_MOD_GO: begin
        cmd.mod_start = 1'b1;
        state_nxt     = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (sts.mod_done) begin
          cmd.piv_ld = 1'b1;
          state_nxt  = S_PV_A;
        end
      end
      S_PV_A: begin
        cmd.rd_sel = RD_LO;
        state_nxt  = S_PV_B;
      end
      S_PV_B: begin
        cmd.rd_sel = RD_PIV;
        cmd.tmp_ld = 1'b1;
        state_nxt  = S_PV_C;
      end
      S_PV_C: begin
        cmd.pv_ld  = 1'b1;
        cmd.wr_sel = WR_LO_RDATA;
        state_nxt  = S_PV_D;
      end
      S_PV_D: begin
        cmd.wr_sel    = WR_PIV_TMP;
        cmd.swp_inc   = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.rd_sel = RD_J;
        state_nxt  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.cmp_inc = 1'b1;
        if (sts.less) begin
          cmd.tmp_ld  = 1'b1;
          cmd.mid_inc = 1'b1;
          state_nxt   = S_SW_RD;
        end else if (sts.j_at_hi) begin
          state_nxt = S_FIN_RD;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SW_RD: begin
        cmd.rd_sel = RD_MID;
        state_nxt  = S_SW_A;
      end
      S_SW_A: begin
        cmd.wr_sel = WR_J_RDATA;
        state_nxt  = S_SW_B;
      end
      S_SW_B: begin
        cmd.wr_sel  = WR_MID_TMP;
        cmd.swp_inc = 1'b1;
        if (sts.j_at_hi) begin
          state_nxt = S_FIN_RD;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_FIN_RD: begin
        cmd.rd_sel = RD_MID;
        state_nxt  = S_FIN_A;
      end
      S_FIN_A: begin
        cmd.wr_sel  = WR_LO_RDATA;
        cmd.swp_inc = 1'b1;
        state_nxt   = S_FIN_B;
      end
      S_FIN_B: begin
        cmd.wr_sel = WR_MID_PV;
        state_nxt  = S_NARROW;
      end
      S_NARROW: begin
        if (sts.rank_eq) begin
          cmd.pos_mid = 1'b1;
          state_nxt   = S_RES_RD;
        end else begin
          cmd.narrow = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_RES_RD: begin
        cmd.rd_sel = RD_POS;
        state_nxt  = S_RES_OUT;
      end
      S_RES_OUT: begin
        cmd.rd_sel = RD_POS;
        if (sts.out_free) begin
          cmd.res_out = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

>>> sv/randomized_quickselect_unit.sv
// Top level of the randomized quickselect unit: controller plus datapath.
// Loading: one element per cycle; in_ready is high only while the list is loading.
// Each partition round: setup, remainder unit (LFSR mod window), pivot swap to the low end,
// a Lomuto scan of the window with a swap for each smaller element, then a close that places the pivot.
// Result: held in an output register until taken.
// Reset (rst_n low, synchronous): control cleared, LFSR loads 1, store contents undefined.
`timescale 1ns / 1ps

module randomized_quickselect_unit #(
  parameter int MAX_ITEMS = rqs_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rqs_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rqs_pkg::out_item_t            out_item,
  input  logic                          cfg_wr_en,
  input  logic [rqs_pkg::SEED_BITS-1:0] cfg_wr_data
);
  import rqs_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller walks the store: pivot pick, Lomuto scan, final swap,
  // then narrows the window toward the wanted rank until it is found.
  rqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the element store, window/rank registers, the pivot
  // LFSR (seeded from cfg), saturating counters and the result register.
  // A finished result sits in the output register, so the next list can
  // begin its transfer while the previous result waits for out_ready.
  rqs_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
